// ===== sv/srf_pkg.sv =====
// Package for the secant root finder: field widths, register indexes, status codes.
// No dependencies; used by the interfaces, the top level and the checker.
package srf_pkg;
	localparam int FRAC_BITS_DEF = 32;
	localparam int VAL_W = 64;
	localparam int ERR_W = 48;
	localparam int ITER_W = 8;
	localparam int IDX_W = 8;
	localparam int STAT_W = 2;

	localparam logic [IDX_W-1:0] REG_ERROR_LIMIT = 8'd0;
	localparam logic [IDX_W-1:0] REG_ITER_LIMIT = 8'd1;

	localparam logic [ERR_W-1:0] ERROR_LIMIT_RST = 48'd1;
	localparam logic [ITER_W-1:0] ITER_LIMIT_RST = 8'd64;

	localparam logic [STAT_W-1:0] ST_CONVERGED = 2'd0;
	localparam logic [STAT_W-1:0] ST_LIMIT = 2'd1;
	localparam logic [STAT_W-1:0] ST_ZERO = 2'd2;
endpackage

// ===== sv/srf_ifs.sv =====
// Channel interfaces of the secant root finder: input, result and configuration.
// Depends on srf_pkg.
interface srf_in_if;
	logic valid;
	logic ready;
	logic func;
	logic signed [srf_pkg::VAL_W-1:0] x_first;
	logic signed [srf_pkg::VAL_W-1:0] x_second;
	modport source (output valid, func, x_first, x_second, input ready);
	modport sink (input valid, func, x_first, x_second, output ready);
endinterface

interface srf_out_if;
	logic valid;
	logic ready;
	logic signed [srf_pkg::VAL_W-1:0] root;
	logic [srf_pkg::STAT_W-1:0] status;
	logic [srf_pkg::ITER_W-1:0] steps_taken;
	modport source (output valid, root, status, steps_taken, input ready);
	modport sink (input valid, root, status, steps_taken, output ready);
endinterface

interface srf_cfg_if;
	logic valid;
	logic ready;
	logic [srf_pkg::IDX_W-1:0] index;
	logic [srf_pkg::VAL_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== sv/secant_root_finder_top.sv =====
// Secant root finder, top level: sequencer around one shared 32x32 multiplier
// and a one-bit-per-cycle divider. Depends on srf_pkg and srf_ifs.
//
// channel  | modport | payload                         | beat when
// in_ch    | sink    | func, x_first, x_second         | valid && ready
// out_ch   | source  | root, status, steps_taken       | valid && ready
// cfg      | sink    | index, data                     | valid && ready (ready always high)
//
// A request first forms f(x_first) with one product (x^2) or two (x^3); each
// secant step then forms f of the newer estimate the same way, one product for
// the numerator, a 128-bit restoring division and one product for the stop test,
// the divider loop being the longest; a 64x64 product sums four partial products.
// Reset clears the registers to their reset values and the sequencer to idle.
// A finished result waits in the output register; a new item is taken meanwhile
// and only its own completion waits for that register to drain.
module secant_root_finder_top #(
	parameter int FRAC_BITS = srf_pkg::FRAC_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	srf_in_if.sink in_ch,
	srf_out_if.source out_ch,
	srf_cfg_if.sink cfg
);
	localparam int W = srf_pkg::VAL_W;
	localparam logic [W-1:0] SIGN_V = {1'b1, {(W-1){1'b0}}};
	localparam logic [W-1:0] MAXP_V = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] TWO_V = W'(2) << FRAC_BITS;
	localparam logic [W-1:0] THREE_V = W'(3) << FRAC_BITS;

	typedef enum logic [3:0] {
		S_IDLE, S_TSQ, S_MUL, S_TSQD, S_TCUD, S_SLOPE,
		S_DIVI, S_DIV, S_DIVD, S_CONV, S_FIN
	} state_t;

	function automatic logic [W-1:0] mag(input logic [W-1:0] v);
		return v[W-1] ? (W'(0) - v) : v;
	endfunction

	function automatic logic [W-1:0] from_mag(input logic [W-1:0] m, input logic neg,
			input logic ovf);
		if (neg)
			return (ovf || m > SIGN_V) ? SIGN_V : (W'(0) - m);
		return (ovf || m > MAXP_V) ? MAXP_V : m;
	endfunction

	function automatic logic [W-1:0] sat_sub(input logic [W-1:0] a, input logic [W-1:0] b);
		logic [W-1:0] r;
		r = a - b;
		if (a[W-1] != b[W-1] && r[W-1] != a[W-1])
			return a[W-1] ? SIGN_V : MAXP_V;
		return r;
	endfunction

	// configuration registers
	logic [srf_pkg::ERR_W-1:0] err_lim_q;
	logic [srf_pkg::ITER_W-1:0] iter_lim_q;

	state_t state_q, ret_q;
	logic func_q, sel_q, neg_q, qneg_q;
	logic [W-1:0] x0_q, x1_q, x2_q, f0_q, f1_q, dy_q;
	logic [W-1:0] mul_a_q, mul_b_q;
	logic [1:0] mcnt_q;
	logic [2*W-1:0] acc_q, dq_q;
	logic [W:0] rem_q;
	logic [6:0] dcnt_q;
	logic [srf_pkg::ITER_W-1:0] steps_q;
	logic [W-1:0] res_root_q;
	logic [srf_pkg::STAT_W-1:0] res_stat_q;

	logic ovalid_q;
	logic [W-1:0] root_q;
	logic [srf_pkg::STAT_W-1:0] stat_q;
	logic [srf_pkg::ITER_W-1:0] osteps_q;

	// shared multiplier: one 32x32 partial product per cycle
	logic [31:0] pa, pb;
	logic [W-1:0] pp;
	logic [2*W-1:0] pp_sh;
	logic [W-1:0] cur_x, fx_m, f_val, dy_c, dx_c, q_c, x2_c;
	logic fx_ovf;
	logic [W:0] r2, r2_sub;
	logic ge;
	logic [2*W-1:0] lhs;
	logic conv;

	always_comb begin
		pa = mcnt_q[0] ? mul_a_q[63:32] : mul_a_q[31:0];
		pb = mcnt_q[1] ? mul_b_q[63:32] : mul_b_q[31:0];
		pp = {32'd0, pa} * {32'd0, pb};
		pp_sh = {{W{1'b0}}, pp} << (7'(mcnt_q[0]) + 7'(mcnt_q[1])) * 7'd32;
		cur_x = sel_q ? x1_q : x0_q;
		fx_m = acc_q[FRAC_BITS +: W];
		fx_ovf = (acc_q >> (FRAC_BITS + W)) != '0;
		// function value once the last product is in
		if (state_q == S_TCUD)
			f_val = sat_sub(from_mag(fx_m, neg_q, fx_ovf), THREE_V);
		else
			f_val = sat_sub(from_mag(fx_m, 1'b0, fx_ovf), TWO_V);
		dy_c = sat_sub(f1_q, f0_q);
		dx_c = sat_sub(x1_q, x0_q);
		r2 = {rem_q[W-1:0], dq_q[2*W-1]};
		ge = r2 >= {1'b0, dy_q};
		r2_sub = r2 - {1'b0, dy_q};
		q_c = from_mag(dq_q[W-1:0], qneg_q, dq_q[2*W-1:W] != '0);
		x2_c = sat_sub(x1_q, q_c);
		// unsigned distance between the estimates, scaled by 2^48
		lhs = {{W{1'b0}}, (sat_sub(x2_q, x1_q) == '0 ? W'(0) :
			((x2_q[W-1] != x1_q[W-1] ? !x2_q[W-1] : x2_q >= x1_q) ?
			x2_q - x1_q : x1_q - x2_q))} << 48;
		conv = lhs <= acc_q;
	end

	assign in_ch.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;
	assign out_ch.valid = ovalid_q;
	assign out_ch.root = root_q;
	assign out_ch.status = stat_q;
	assign out_ch.steps_taken = osteps_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			err_lim_q <= srf_pkg::ERROR_LIMIT_RST;
			iter_lim_q <= srf_pkg::ITER_LIMIT_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				srf_pkg::REG_ERROR_LIMIT: err_lim_q <= cfg.data[srf_pkg::ERR_W-1:0];
				srf_pkg::REG_ITER_LIMIT: iter_lim_q <= cfg.data[srf_pkg::ITER_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ret_q <= S_IDLE;
			ovalid_q <= 1'b0;
			mcnt_q <= '0;
			dcnt_q <= '0;
			steps_q <= '0;
			sel_q <= 1'b0;
		end else begin
			// drop the beat once taken, unless the finish step reloads it
			if (ovalid_q && out_ch.ready && state_q != S_FIN)
				ovalid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_ch.valid) begin
						func_q <= in_ch.func;
						x0_q <= in_ch.x_first;
						x1_q <= in_ch.x_second;
						steps_q <= '0;
						sel_q <= 1'b0;
						if (iter_lim_q == '0) begin
							res_root_q <= in_ch.x_second;
							res_stat_q <= srf_pkg::ST_LIMIT;
							state_q <= S_FIN;
						end else begin
							state_q <= S_TSQ;
						end
					end
				end
				S_TSQ: begin
					// square the current estimate
					mul_a_q <= mag(cur_x);
					mul_b_q <= mag(cur_x);
					acc_q <= '0;
					mcnt_q <= '0;
					ret_q <= S_TSQD;
					state_q <= S_MUL;
				end
				S_MUL: begin
					acc_q <= acc_q + pp_sh;
					mcnt_q <= mcnt_q + 2'd1;
					if (mcnt_q == 2'd3)
						state_q <= ret_q;
				end
				S_TSQD, S_TCUD: begin
					if (state_q == S_TSQD && func_q) begin
						// cube: saturated square times x
						mul_a_q <= from_mag(fx_m, 1'b0, fx_ovf);
						mul_b_q <= mag(cur_x);
						neg_q <= cur_x[W-1];
						acc_q <= '0;
						mcnt_q <= '0;
						ret_q <= S_TCUD;
						state_q <= S_MUL;
					end else if (!sel_q) begin
						f0_q <= f_val;
						sel_q <= 1'b1;
						state_q <= S_TSQ;
					end else begin
						f1_q <= f_val;
						state_q <= S_SLOPE;
					end
				end
				S_SLOPE: begin
					if (dy_c == '0) begin
						res_root_q <= x1_q;
						res_stat_q <= srf_pkg::ST_ZERO;
						state_q <= S_FIN;
					end else begin
						dy_q <= mag(dy_c);
						qneg_q <= (f1_q[W-1] != dx_c[W-1]) != dy_c[W-1];
						mul_a_q <= mag(f1_q);
						mul_b_q <= mag(dx_c);
						acc_q <= '0;
						mcnt_q <= '0;
						ret_q <= S_DIVI;
						state_q <= S_MUL;
					end
				end
				S_DIVI: begin
					dq_q <= acc_q;
					rem_q <= '0;
					dcnt_q <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					// restoring division, quotient bits shift in at the bottom
					rem_q <= ge ? r2_sub : r2;
					dq_q <= {dq_q[2*W-2:0], ge};
					dcnt_q <= dcnt_q + 7'd1;
					if (dcnt_q == 7'd127)
						state_q <= S_DIVD;
				end
				S_DIVD: begin
					x2_q <= x2_c;
					steps_q <= steps_q + 1'b1;
					res_root_q <= x2_c;
					if (x2_c == '0) begin
						res_stat_q <= srf_pkg::ST_ZERO;
						state_q <= S_FIN;
					end else begin
						mul_a_q <= {{(W-srf_pkg::ERR_W){1'b0}}, err_lim_q};
						mul_b_q <= mag(x2_c);
						acc_q <= '0;
						mcnt_q <= '0;
						ret_q <= S_CONV;
						state_q <= S_MUL;
					end
				end
				S_CONV: begin
					if (conv) begin
						res_stat_q <= srf_pkg::ST_CONVERGED;
						state_q <= S_FIN;
					end else begin
						// advance the pair; f(x1) becomes the old value
						x0_q <= x1_q;
						x1_q <= x2_q;
						f0_q <= f1_q;
						res_stat_q <= srf_pkg::ST_LIMIT;
						if (steps_q == iter_lim_q)
							state_q <= S_FIN;
						else
							state_q <= S_TSQ;
					end
				end
				S_FIN: begin
					if (!ovalid_q || out_ch.ready) begin
						root_q <= res_root_q;
						stat_q <= res_stat_q;
						osteps_q <= steps_q;
						ovalid_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ===== sv/srf_checker.sv =====
// Port-level checker for the secant root finder and its bind to the top level.
// Depends on srf_pkg and secant_root_finder_top.
module srf_checker (
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_ready,
	input logic [srf_pkg::VAL_W-1:0] root,
	input logic [srf_pkg::STAT_W-1:0] status,
	input logic [srf_pkg::ITER_W-1:0] steps_taken
);
	// hold the beat until taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");
	a_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(root) && $stable(status) && $stable(steps_taken))
		else $error("result changed while stalled");
	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status == srf_pkg::ST_CONVERGED || status == srf_pkg::ST_LIMIT ||
			status == srf_pkg::ST_ZERO)
		else $error("unused status code");
	a_conv_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == srf_pkg::ST_CONVERGED |-> steps_taken != '0)
		else $error("converged without a step");
	a_valid_known: assert property (@(posedge clk) disable iff (!arst_n)
		!$isunknown(out_valid))
		else $error("result valid unknown");
endmodule

bind secant_root_finder_top srf_checker u_srf_checker (
	.clk(clk),
	.arst_n(arst_n),
	.out_valid(out_ch.valid),
	.out_ready(out_ch.ready),
	.root(out_ch.root),
	.status(out_ch.status),
	.steps_taken(out_ch.steps_taken)
);

// ===== tb/sv/srf_tb_ifs.sv =====
// Interface instances are taken from srf_ifs; this file holds the shared types
// and saturation constants of the bench. Depends on srf_pkg.
package srf_tb_pkg;
	import srf_pkg::*;

	typedef logic [63:0] u64_t;
	typedef logic [127:0] u128_t;

	localparam u64_t SIGN_MIN = 64'h8000_0000_0000_0000;
	localparam u64_t SIGN_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

	typedef struct packed {
		logic [VAL_W-1:0] root;
		logic [STAT_W-1:0] status;
		logic [ITER_W-1:0] steps_taken;
	} root_res_t;
endpackage

// ===== tb/sv/secant_root_finder_top_tb.sv =====
// Testbench for secant_root_finder_top: drives search requests and register
// writes, predicts each root, status and step count, and checks every beat.
// Depends on srf_pkg, srf_ifs and srf_tb_pkg.
module secant_root_finder_top_tb;
	import srf_pkg::*;
	import srf_tb_pkg::*;

	localparam int FB = FRAC_BITS_DEF;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	always #4 clk = ~clk;

	srf_in_if in_ch();
	srf_out_if out_ch();
	srf_cfg_if cfg();

	secant_root_finder_top #(.FRAC_BITS(FB)) DUT (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg(cfg)
	);

	// Bench copy of the two registers
	logic [ERR_W-1:0] err_lim;
	logic [ITER_W-1:0] iter_lim;

	root_res_t roots_due[$];
	int n_fail = 0;
	bit idle_on = 1'b1;
	int hold_off = 0;
	bit long_stall = 1'b0;

	// ---------------- fixed-point predictor ----------------
	function automatic u64_t magn(u64_t v);
		return v[63] ? -v : v;
	endfunction

	function automatic u64_t clamp_mag(u128_t m, bit neg);
		if (neg) return (m > {64'd0, SIGN_MIN}) ? SIGN_MIN : -m[63:0];
		return (m > {64'd0, SIGN_MAX}) ? SIGN_MAX : m[63:0];
	endfunction

	function automatic u64_t sub_sat(u64_t a, u64_t b);
		u64_t r;
		r = a - b;
		if (a[63] != b[63] && r[63] != a[63]) return a[63] ? SIGN_MIN : SIGN_MAX;
		return r;
	endfunction

	function automatic u64_t mul_q(u64_t a, u64_t b);
		u128_t p;
		p = {64'd0, magn(a)} * {64'd0, magn(b)};
		return clamp_mag(p >> FB, a[63] ^ b[63]);
	endfunction

	function automatic u64_t eval_f(bit fsel, u64_t x);
		u64_t sq;
		sq = mul_q(x, x);
		if (fsel) return sub_sat(mul_q(sq, x), u64_t'(3) << FB);
		return sub_sat(sq, u64_t'(2) << FB);
	endfunction

	function automatic root_res_t solve_secant(bit fsel, u64_t x0, u64_t x1);
		root_res_t r;
		u64_t f0, f1, dx, dy, x2, dm;
		u128_t num, q;
		int steps;
		r.root = x1; r.status = ST_LIMIT; steps = 0;
		while (steps < iter_lim) begin
			f0 = eval_f(fsel, x0);
			f1 = eval_f(fsel, x1);
			dy = sub_sat(f1, f0);
			if (dy == 0) begin
				r.root = x1; r.status = ST_ZERO;
				break;
			end
			dx = sub_sat(x1, x0);
			num = {64'd0, magn(f1)} * {64'd0, magn(dx)};
			q = num / {64'd0, magn(dy)};
			x2 = sub_sat(x1, clamp_mag(q, f1[63] ^ dx[63] ^ dy[63]));
			steps++;
			r.root = x2;
			if (x2 == 0) begin
				r.status = ST_ZERO;
				break;
			end
			dm = ($signed(x2) >= $signed(x1)) ? x2 - x1 : x1 - x2;
			if (({64'd0, dm} << 48) <= {80'd0, err_lim} * {64'd0, magn(x2)}) begin
				r.status = ST_CONVERGED;
				break;
			end
			x0 = x1; x1 = x2; r.status = ST_LIMIT;
		end
		r.steps_taken = steps[7:0];
		return r;
	endfunction

	// ---------------- channel drivers ----------------
	// Drop valid for a random burst of idle cycles.
	task automatic sender_gap();
		int n;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			n = $urandom_range(1, 15);
			in_ch.valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// Send one search request; hold valid until the beat.
	task automatic send_search(bit fsel, u64_t a, u64_t b);
		sender_gap();
		in_ch.valid <= 1'b1;
		in_ch.func <= fsel;
		in_ch.x_first <= a;
		in_ch.x_second <= b;
		roots_due.push_back(solve_secant(fsel, a, b));
		do @(posedge clk); while (!in_ch.ready);
	endtask

	task automatic write_reg(logic [IDX_W-1:0] idx, u64_t val);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= val;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		@(posedge clk);
		if (idx == REG_ERROR_LIMIT) err_lim = val[ERR_W-1:0];
		else iter_lim = val[ITER_W-1:0];
	endtask

	// Drain all results, then let the clock run on before touching registers.
	task automatic wait_drained();
		in_ch.valid <= 1'b0;
		while (roots_due.size() != 0) @(posedge clk);
		repeat (400) @(posedge clk);
	endtask

	function automatic u64_t rand64();
		return {$urandom(), $urandom()};
	endfunction

	// Mostly near-root guesses, sometimes wide or raw patterns
	function automatic u64_t rand_guess();
		case ($urandom_range(0, 9))
			0: return rand64();
			1: return u64_t'($signed(rand64()) >>> $urandom_range(20, 62));
			default: return u64_t'($signed({$urandom_range(0, 7) - 4, $urandom()}));
		endcase
	endfunction

	// ---------------- result checker ----------------
	always @(posedge clk) begin
		root_res_t want;
		if (arst_n) begin
			if (long_stall) begin
				out_ch.ready <= 1'b0;
			end else if (hold_off > 0) begin
				hold_off <= hold_off - 1;
				out_ch.ready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 19) == 0) begin
				hold_off <= $urandom_range(0, 14);
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= 1'b1;
			end
			if (out_ch.valid && out_ch.ready) begin
				if (roots_due.size() == 0) begin
					$error("result beat with nothing expected");
					n_fail++;
				end else begin
					want = roots_due.pop_front();
					if (out_ch.root !== want.root) begin
						$error("root: expected %h, got %h", want.root, out_ch.root);
						n_fail++;
					end
					if (out_ch.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, out_ch.status);
						n_fail++;
					end
					if (out_ch.steps_taken !== want.steps_taken) begin
						$error("steps_taken: expected %0d, got %0d",
							want.steps_taken, out_ch.steps_taken);
						n_fail++;
					end
				end
			end
		end
	end

	// ---------------- tests ----------------
	// Register reset values, extremes of the guesses, zero slope, saturation and the limits.
	task automatic test_directed();
		u64_t one;
		one = u64_t'(1) << FB;
		send_search(1'b0, one, 2 * one);
		send_search(1'b1, one, 2 * one);
		send_search(1'b0, one, one);                  // zero slope, equal guesses
		send_search(1'b0, -one, one);                 // zero slope, symmetric
		send_search(1'b0, SIGN_MIN, SIGN_MAX);        // saturated function values
		send_search(1'b1, SIGN_MAX, SIGN_MIN);
		send_search(1'b1, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF);
		send_search(1'b0, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
		send_search(1'b1, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
		send_search(1'b0, -2 * one, -one);            // negative root
		send_search(1'b0, 64'd0, 64'd1);
		wait_drained();
		write_reg(REG_ERROR_LIMIT, 64'd0);            // exact convergence only
		write_reg(REG_ITER_LIMIT, 64'd255);
		send_search(1'b0, one, 2 * one);
		send_search(1'b1, one, 2 * one);
		wait_drained();
		write_reg(REG_ITER_LIMIT, 64'd0);             // no step at all
		send_search(1'b1, one, 3 * one);
		send_search(1'b0, SIGN_MIN, SIGN_MIN);
		wait_drained();
		write_reg(REG_ERROR_LIMIT, 64'hFFFF_FFFF_FFFF); // loosest limit
		write_reg(REG_ITER_LIMIT, 64'd1);
		send_search(1'b0, one, 2 * one);
		send_search(1'b1, 3 * one, 4 * one);
		wait_drained();
	endtask

	task automatic test_random(int n);
		repeat (n) send_search($urandom_range(0, 1), rand_guess(), rand_guess());
	endtask

	// Hold the receiver off for a long stretch so the input stalls.
	task automatic test_backpressure();
		fork
			begin
				long_stall = 1'b1;
				repeat (20000) @(posedge clk);
				long_stall = 1'b0;
			end
		join_none
		test_random(6);
	endtask

	task automatic random_regs();
		write_reg(REG_ERROR_LIMIT, {16'd0, 16'($urandom_range(0, 65535)), $urandom()});
		write_reg(REG_ITER_LIMIT, $urandom_range(0, 1) ? 64'd255 :
			64'($urandom_range(1, 40)));
	endtask

	initial begin
		in_ch.valid = 1'b0; in_ch.func = 1'b0;
		in_ch.x_first = '0; in_ch.x_second = '0;
		out_ch.ready = 1'b0;
		cfg.valid = 1'b0; cfg.index = '0; cfg.data = '0;
		err_lim = ERROR_LIMIT_RST;
		iter_lim = ITER_LIMIT_RST;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		write_reg(REG_ERROR_LIMIT, 64'd1 << 20);
		write_reg(REG_ITER_LIMIT, 64'd64);
		test_random(80);
		test_backpressure();
		wait_drained();
		random_regs();
		test_random(80);
		wait_drained();
		random_regs();
		test_random(60);
		wait_drained();
		// Last stretch runs flat out
		idle_on = 1'b0;
		write_reg(REG_ERROR_LIMIT, 64'd4096);
		write_reg(REG_ITER_LIMIT, 64'd20);
		test_random(60);
		wait_drained();

		if (n_fail == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin
		#500_000_000;
		$display("TEST FAILED");
		$finish;
	end
endmodule

// ===== files.f =====
sv/srf_pkg.sv
sv/srf_ifs.sv
sv/secant_root_finder_top.sv
sv/srf_checker.sv
tb/sv/srf_tb_ifs.sv
tb/sv/secant_root_finder_top_tb.sv
